/* rtl/core/hpb_pkg.sv */
// Shared constants, register codes and controller/datapath interface types.
package hpb_pkg;

  // Fixed field widths
  localparam int DEATH_W  = 26;
  localparam int DIM_W    = 4;
  localparam int CFG_AW   = 2;
  localparam int OUT_TW   = ((DEATH_W + 7) / 8) * 8;
  localparam int USER_W   = 2;

  // Parameter defaults
  localparam int DEF_MAX_POINTS = 32;
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 8;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_DIM        = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_RADIUS = 2'd1;

  // Register reset values
  localparam logic [DIM_W-1:0]   DIM_RESET    = 4'd2;
  localparam logic [DEATH_W-1:0] RADIUS_RESET = 26'h3FF_FFFF;

  // Commands from the controller
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic init;
    logic i_clr;
    logic i_inc;
    logic scan_clr;
    logic scan_step;
    logic take_edge;
    logic take_root;
    logic dist_clr;
    logic rd;
    logic relax;
    logic cl_load;
    logic osel_clr;
    logic osel_step;
    logic osel_take;
    logic out_fin;
    logic out_inf;
    logic out_err;
  } hpb_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic n_over;
    logic rem_ge;
    logic rem_nz;
    logic i_end;
    logic best_found;
    logic first_found;
    logic vis_i;
    logic k_end;
    logic pipe_busy;
    logic fin_done;
    logic i_end_nd;
    logic sqrt_busy;
    logic out_last;
  } hpb_sts_t;

endpackage

/* rtl/core/hpb_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
module hpb_isqrt import hpb_pkg::*; #(
  parameter int IW = 2 * DEF_COORD_BITS + 4 + 2 * DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [IW-1:0]      val,
  output logic               busy,
  output logic [DEATH_W-1:0] root
);

  localparam int W0 = (IW > DEATH_W) ? IW : DEATH_W;
  localparam int W  = W0 + (W0 % 2);

  logic [W-1:0] x_r, r_r, b_r;
  logic         busy_r;
  logic [W-1:0] t;

  assign t = r_r + b_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (b_r == W'(1))) begin
      busy_r <= 1'b0;
    end
  end

  // Bit-pair restoring step
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= W'(val);
      r_r <= '0;
      b_r <= W'(1) << (W - 2);
    end else if (busy_r) begin
      if (x_r >= t) begin
        x_r <= x_r - t;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[DEATH_W-1:0];

endmodule

/* rtl/core/hpb_datapath.sv */
// Point store, distance pipeline, spanning-forest tables and bar output registers.
module hpb_datapath import hpb_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpb_cmd_t                     cmd,
  output hpb_sts_t                     sts,
  input  logic signed [COORD_BITS-1:0] coord,
  input  logic                         cfg_we,
  input  logic [CFG_AW-1:0]            cfg_addr,
  input  logic [DEATH_W-1:0]           cfg_wdata,
  output logic [DEATH_W-1:0]           death,
  output logic                         infinite,
  output logic                         error,
  output logic                         bar_last
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int DEPTH = MAX_POINTS * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SAT   = DEPTH + MAX_DIM;
  localparam int CNTW  = $clog2(SAT + 1);
  localparam int NW    = $clog2(MAX_POINTS + 2);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int XW    = PW + DW;
  localparam int SQW   = 2 * COORD_BITS + 1 + $clog2(MAX_DIM);
  localparam int LIMW  = 2 * DEATH_W;
  localparam int CW    = (SQW > LIMW) ? SQW : LIMW;
  localparam int IW    = SQW + 2 * FRAC_BITS;

  // Configuration registers
  logic [DIM_W-1:0]   dim_r;
  logic [DEATH_W-1:0] rad_r;
  logic [DW-1:0]      dim_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
      rad_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIM:        dim_r <= cfg_wdata[DIM_W-1:0];
        REG_MAX_RADIUS: rad_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize clamps to the store's row width
  always_comb begin
    if (dim_r == '0) begin
      dim_eff = DW'(1);
    end else if (32'(dim_r) > MAX_DIM) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(dim_r);
    end
  end

  // Control registers
  logic [CNTW-1:0]       cnt_r, rem_r;
  logic [NW-1:0]         n_r, nd_r, comps_r, o_r, cl_r;
  logic [PW-1:0]         i_r, v_r, best_r, first_r, midx_r;
  logic [DW-1:0]         k_r;
  logic                  p1_r, p2_r, bf_r, ff_r, mf_r;
  logic [MAX_POINTS-1:0] vis_r, hk_r, used_r;

  // Payload registers
  logic signed [COORD_BITS-1:0] pmem [DEPTH];
  logic signed [COORD_BITS-1:0] rv_r, ru_r;
  logic signed [COORD_BITS:0]   diff_r;
  logic [SQW-1:0]               acc_r, bkey_r, mval_r;
  logic [SQW-1:0]               key_r [MAX_POINTS];
  logic [SQW-1:0]               dth_r [MAX_POINTS];
  logic [LIMW-1:0]              limit_r;
  logic [DEATH_W-1:0]           od_r;
  logic                         oinf_r, oerr_r, olast_r;

  // Derived values
  logic                         we;
  logic [XW-1:0]                av_x, au_x;
  logic signed [2*COORD_BITS+1:0] sq_w;
  logic [LIMW-1:0]              rad_sq;
  logic                         keep;
  logic [NW-1:0]                i_x;
  logic                         sq_busy;
  logic [DEATH_W-1:0]           sq_root;

  assign we     = cmd.load && (cnt_r < CNTW'(DEPTH));
  assign av_x   = XW'(v_r) * XW'(dim_eff) + XW'(k_r);
  assign au_x   = XW'(i_r) * XW'(dim_eff) + XW'(k_r);
  assign sq_w   = diff_r * diff_r;
  assign rad_sq = LIMW'(rad_r) * LIMW'(rad_r);
  assign keep   = CW'(acc_r) <= CW'(limit_r);
  assign i_x    = NW'(i_r);

  // Point store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      pmem[cnt_r[AW-1:0]] <= coord;
    end
    rv_r <= pmem[av_x[AW-1:0]];
    ru_r <= pmem[au_x[AW-1:0]];
  end

  // Distance pipeline: difference, then square and accumulate
  always_ff @(posedge clk) begin
    diff_r <= {rv_r[COORD_BITS-1], rv_r} - {ru_r[COORD_BITS-1], ru_r};
    if (cmd.dist_clr) begin
      acc_r <= '0;
    end else if (p2_r) begin
      acc_r <= acc_r + SQW'(unsigned'(sq_w[2*COORD_BITS:0]));
    end
    if (cmd.init) begin
      limit_r <= rad_sq >> (2 * FRAC_BITS);
    end
  end

  // Counters, flags and visit state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rem_r   <= '0;
      n_r     <= '0;
      nd_r    <= '0;
      comps_r <= '0;
      o_r     <= '0;
      cl_r    <= '0;
      i_r     <= '0;
      v_r     <= '0;
      k_r     <= '0;
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      bf_r    <= 1'b0;
      ff_r    <= 1'b0;
      mf_r    <= 1'b0;
      vis_r   <= '0;
      hk_r    <= '0;
      used_r  <= '0;
    end else begin
      p1_r <= cmd.rd;
      p2_r <= p1_r;
      if (cmd.load && (cnt_r < CNTW'(SAT))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      // Points = count / dim by repeated subtraction
      if (cmd.div_start) begin
        rem_r <= cnt_r;
        n_r   <= '0;
        cnt_r <= '0;
      end
      if (cmd.div_step) begin
        rem_r <= rem_r - CNTW'(dim_eff);
        n_r   <= n_r + 1'b1;
      end
      if (cmd.init) begin
        vis_r   <= '0;
        hk_r    <= '0;
        used_r  <= '0;
        nd_r    <= '0;
        comps_r <= '0;
        o_r     <= '0;
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.dist_clr) begin
        k_r <= '0;
      end else if (cmd.rd) begin
        k_r <= k_r + 1'b1;
      end
      // Nearest unvisited vertex and first unvisited vertex
      if (cmd.scan_clr) begin
        bf_r <= 1'b0;
        ff_r <= 1'b0;
      end else if (cmd.scan_step && !vis_r[i_r]) begin
        if (!ff_r) begin
          ff_r    <= 1'b1;
          first_r <= i_r;
        end
        if (hk_r[i_r] && (!bf_r || (key_r[i_r] < bkey_r))) begin
          bf_r   <= 1'b1;
          best_r <= i_r;
        end
      end
      if (cmd.take_edge) begin
        nd_r          <= nd_r + 1'b1;
        v_r           <= best_r;
        vis_r[best_r] <= 1'b1;
      end
      if (cmd.take_root) begin
        comps_r        <= comps_r + 1'b1;
        v_r            <= first_r;
        vis_r[first_r] <= 1'b1;
      end
      if (cmd.relax && keep && (!hk_r[i_r] || (acc_r < key_r[i_r]))) begin
        hk_r[i_r] <= 1'b1;
      end
      // Smallest unsent death
      if (cmd.osel_clr) begin
        mf_r <= 1'b0;
      end else if (cmd.osel_step && !used_r[i_r] && (!mf_r || (dth_r[i_r] < mval_r))) begin
        mf_r   <= 1'b1;
        midx_r <= i_r;
      end
      if (cmd.osel_take) begin
        used_r[midx_r] <= 1'b1;
        o_r            <= o_r + 1'b1;
      end
      if (cmd.cl_load) begin
        cl_r <= comps_r;
      end else if (cmd.out_inf) begin
        cl_r <= cl_r - 1'b1;
      end
    end
  end

  // Key, death and minimum values
  always_ff @(posedge clk) begin
    if (cmd.scan_step && !vis_r[i_r] && hk_r[i_r] && (!bf_r || (key_r[i_r] < bkey_r))) begin
      bkey_r <= key_r[i_r];
    end
    if (cmd.take_edge) begin
      dth_r[nd_r[PW-1:0]] <= bkey_r;
    end
    if (cmd.relax && keep && (!hk_r[i_r] || (acc_r < key_r[i_r]))) begin
      key_r[i_r] <= acc_r;
    end
    if (cmd.osel_step && !used_r[i_r] && (!mf_r || (dth_r[i_r] < mval_r))) begin
      mval_r <= dth_r[i_r];
    end
  end

  hpb_isqrt #(.IW(IW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.osel_take),
    .val   (IW'(mval_r) << (2 * FRAC_BITS)),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_fin) begin
      od_r    <= sq_root;
      oinf_r  <= 1'b0;
      oerr_r  <= 1'b0;
      olast_r <= 1'b0;
    end else if (cmd.out_inf) begin
      od_r    <= '0;
      oinf_r  <= 1'b1;
      oerr_r  <= 1'b0;
      olast_r <= (cl_r == NW'(1));
    end else if (cmd.out_err) begin
      od_r    <= '0;
      oinf_r  <= 1'b0;
      oerr_r  <= 1'b1;
      olast_r <= 1'b1;
    end
  end

  assign death    = od_r;
  assign infinite = oinf_r;
  assign error    = oerr_r;
  assign bar_last = olast_r;

  // Status
  always_comb begin
    sts.n_over      = n_r > NW'(MAX_POINTS);
    sts.rem_ge      = rem_r >= CNTW'(dim_eff);
    sts.rem_nz      = rem_r != '0;
    sts.i_end       = i_x == (n_r - NW'(1));
    sts.best_found  = bf_r;
    sts.first_found = ff_r;
    sts.vis_i       = vis_r[i_r];
    sts.k_end       = k_r == (dim_eff - DW'(1));
    sts.pipe_busy   = p1_r | p2_r;
    sts.fin_done    = o_r == nd_r;
    sts.i_end_nd    = i_x == (nd_r - NW'(1));
    sts.sqrt_busy   = sq_busy;
    sts.out_last    = olast_r;
  end

  // Checks
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(SAT)) else $error("coordinate count past saturation");
  a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r < NW'(MAX_POINTS)) else $error("more merges than a forest allows");
  a_root_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_edge |-> !vis_r[best_r]) else $error("merge onto visited vertex");
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    o_r <= nd_r) else $error("more finite bars sent than merges");

endmodule

/* rtl/core/hpb_ctrl.sv */
// Sequencer: load, point count, spanning forest, ordered bar output.
module hpb_ctrl import hpb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output hpb_cmd_t cmd,
  input  hpb_sts_t sts
);

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_DIV0  = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_ERR   = 5'd3;
  localparam logic [4:0] S_INIT  = 5'd4;
  localparam logic [4:0] S_SEL0  = 5'd5;
  localparam logic [4:0] S_SEL   = 5'd6;
  localparam logic [4:0] S_TAKE  = 5'd7;
  localparam logic [4:0] S_REL0  = 5'd8;
  localparam logic [4:0] S_REL   = 5'd9;
  localparam logic [4:0] S_DIST  = 5'd10;
  localparam logic [4:0] S_DRAIN = 5'd11;
  localparam logic [4:0] S_UPD   = 5'd12;
  localparam logic [4:0] S_OSEL0 = 5'd13;
  localparam logic [4:0] S_OSEL  = 5'd14;
  localparam logic [4:0] S_SQ0   = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_OUTF  = 5'd17;
  localparam logic [4:0] S_INF   = 5'd18;
  localparam logic [4:0] S_OUTI  = 5'd19;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUTF) || (state_r == S_OUTI);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            state_nxt = S_DIV0;
          end
        end
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.n_over) begin
          state_nxt = S_ERR;
        end else if (sts.rem_ge) begin
          cmd.div_step = 1'b1;
        end else if (sts.rem_nz) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_ERR: begin
        cmd.out_err = 1'b1;
        state_nxt   = S_OUTI;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_SEL0;
      end
      S_SEL0: begin
        cmd.scan_clr = 1'b1;
        cmd.i_clr    = 1'b1;
        state_nxt    = S_SEL;
      end
      S_SEL: begin
        cmd.scan_step = 1'b1;
        if (sts.i_end) begin
          state_nxt = S_TAKE;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_TAKE: begin
        if (sts.best_found) begin
          cmd.take_edge = 1'b1;
          state_nxt     = S_REL0;
        end else if (sts.first_found) begin
          cmd.take_root = 1'b1;
          state_nxt     = S_REL0;
        end else begin
          state_nxt = S_OSEL0;
        end
      end
      S_REL0: begin
        cmd.i_clr = 1'b1;
        state_nxt = S_REL;
      end
      S_REL: begin
        if (sts.vis_i) begin
          if (sts.i_end) begin
            state_nxt = S_SEL0;
          end else begin
            cmd.i_inc = 1'b1;
          end
        end else begin
          cmd.dist_clr = 1'b1;
          state_nxt    = S_DIST;
        end
      end
      S_DIST: begin
        cmd.rd = 1'b1;
        if (sts.k_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.relax = 1'b1;
        if (sts.i_end) begin
          state_nxt = S_SEL0;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_REL;
        end
      end
      S_OSEL0: begin
        if (sts.fin_done) begin
          cmd.cl_load = 1'b1;
          state_nxt   = S_INF;
        end else begin
          cmd.osel_clr = 1'b1;
          cmd.i_clr    = 1'b1;
          state_nxt    = S_OSEL;
        end
      end
      S_OSEL: begin
        cmd.osel_step = 1'b1;
        if (sts.i_end_nd) begin
          state_nxt = S_SQ0;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      S_SQ0: begin
        cmd.osel_take = 1'b1;
        state_nxt     = S_SQ;
      end
      S_SQ: begin
        if (!sts.sqrt_busy) begin
          cmd.out_fin = 1'b1;
          state_nxt   = S_OUTF;
        end
      end
      S_OUTF: begin
        if (out_tready) begin
          state_nxt = S_OSEL0;
        end
      end
      S_INF: begin
        cmd.out_inf = 1'b1;
        state_nxt   = S_OUTI;
      end
      S_OUTI: begin
        if (out_tready) begin
          state_nxt = sts.out_last ? S_LOAD : S_INF;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and result side open together");
  a_fin_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUTF) |-> !sts.out_last) else $error("finite bar closes the run");
  a_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> !sts.pipe_busy) else $error("relax before distance settled");

endmodule

/* rtl/core/h0_persistence_barcode_core.sv */
// Top level of the H0 persistence barcode block.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  tdata: coord; tlast: last
//  out_     master     out_tvalid/out_tready tdata: death; tuser: infinite, error; tlast
//  cfg_     write      cfg_we               cfg_addr index, cfg_wdata value
//
// Loading accepts one coordinate per cycle. After the closing coordinate the
// point count is found by repeated subtraction; the spanning forest is then
// built on the single shared distance pipeline. Each finite bar needs a minimum
// search plus the one-bit-per-cycle square root. Reset is synchronous and
// active low; the point store needs no clearing pass. A stalled result holds
// the block; no coordinate is taken until the last bar has been transferred.
module h0_persistence_barcode_core import hpb_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((COORD_BITS+7)/8)*8-1:0]     in_tdata,   // coord
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TW-1:0]                   out_tdata,  // death
  output logic [USER_W-1:0]                   out_tuser,  // infinite, error
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [CFG_AW-1:0]                   cfg_addr,
  input  logic [DEATH_W-1:0]                  cfg_wdata
);

  hpb_cmd_t           cmd;
  hpb_sts_t           sts;
  logic [DEATH_W-1:0] death;
  logic               infinite, error;

  hpb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  hpb_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .coord     (signed'(in_tdata[COORD_BITS-1:0])),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .death     (death),
    .infinite  (infinite),
    .error     (error),
    .bar_last  (out_tlast)
  );

  assign out_tdata = OUT_TW'(death);
  assign out_tuser = {error, infinite};

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the H0 persistence barcode core.
`timescale 1ns / 100ps

module testbench;
  import hpb_pkg::*;

  localparam int NPTS       = DEF_MAX_POINTS;
  localparam int NDIM       = DEF_MAX_DIM;
  localparam int STORE_D    = NPTS * NDIM;
  localparam int COUNT_TOP  = STORE_D + NDIM;
  localparam int FRAC       = DEF_FRAC_BITS;
  localparam int STALL_LIM  = 200000;
  localparam int SETTLE     = 60;
  localparam int RAND_ITEMS = 30;
  localparam int SET_CAP    = 40;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;
  typedef enum int {PAT_ZERO, PAT_EXT, PAT_RAND, PAT_DUP} pat_e;
  typedef enum int {EXP_MODEL, EXP_ONE_INF, EXP_ERR} exp_e;

  typedef struct {
    logic [DEATH_W-1:0] death;
    logic               inf;
    logic               err;
    logic               last;
  } bar_t;

  typedef struct {
    logic [DIM_W-1:0]   dim;
    logic [DEATH_W-1:0] radius;
    int                 ncoord;
    pat_e               pat;
    exp_e               exp;
  } set_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [DEATH_W-1:0] cfg_wdata;

  // predictor state
  longint             coord_mem [STORE_D];
  int                 coord_cnt;
  logic [DIM_W-1:0]   dim_reg;
  logic [DEATH_W-1:0] radius_reg;
  bar_t               bars_due [$];

  idle_e idle_mode = IDLE_NONE;
  int    fails = 0;
  int    quiet_cycles = 0;

  h0_persistence_barcode_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned x = v, r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int uf_root(ref int par [NPTS], input int v);
    int r = v;
    while (par[r] != r) r = par[r];
    return r;
  endfunction

  // Forest of the closed set: an error bar for a bad count, else finite bars in Kruskal order, then survivors
  task automatic close_set();
    int d, n, e, p, ra, rb, comps;
    longint unsigned limit, sq, dl, key;
    longint unsigned esq [$];
    int ea [$], eb [$];
    int par [NPTS];
    bar_t b;
    d = (dim_reg == 0) ? 1 : (dim_reg > NDIM ? NDIM : int'(dim_reg));
    n = coord_cnt / d;
    if (coord_cnt % d != 0 || n > NPTS) begin
      coord_cnt = 0;
      b = '{death: '0, inf: 1'b0, err: 1'b1, last: 1'b1};
      bars_due.insert(bars_due.size(), b);
      return;
    end
    coord_cnt = 0;
    limit = (longint'(radius_reg) * longint'(radius_reg)) >> (2 * FRAC);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        sq = 0;
        for (int k = 0; k < d; k++) begin
          dl = (coord_mem[i*d+k] > coord_mem[j*d+k]) ? coord_mem[i*d+k] - coord_mem[j*d+k]
                                                     : coord_mem[j*d+k] - coord_mem[i*d+k];
          sq += dl * dl;
        end
        if (sq <= limit) begin
          // pairs arrive in (a,b) order, so ties on distance keep their place
          p = esq.size();
          esq.insert(p, sq); ea.insert(p, i); eb.insert(p, j);
          while (p > 0 && esq[p-1] > sq) begin
            esq[p] = esq[p-1]; ea[p] = ea[p-1]; eb[p] = eb[p-1];
            p--;
          end
          esq[p] = sq; ea[p] = i; eb[p] = j;
        end
      end
    for (int i = 0; i < NPTS; i++) par[i] = i;
    for (e = 0; e < esq.size(); e++) begin
      ra = uf_root(par, ea[e]);
      rb = uf_root(par, eb[e]);
      if (ra != rb) begin
        par[rb] = ra;
        key = esq[e] << (2 * FRAC);
        b = '{death: DEATH_W'(floor_sqrt(key)), inf: 1'b0, err: 1'b0, last: 1'b0};
        bars_due.insert(bars_due.size(), b);
      end
    end
    comps = 0;
    for (int i = 0; i < n; i++) if (uf_root(par, i) == i) comps++;
    for (int i = 0; i < comps; i++) begin
      b = '{death: '0, inf: 1'b1, err: 1'b0, last: 1'b0};
      bars_due.insert(bars_due.size(), b);
    end
    bars_due[$].last = 1'b1;
  endtask

  // Predictor step for one accepted coordinate
  task automatic take_coord(input logic signed [15:0] c, input bit lst);
    if (coord_cnt < STORE_D) coord_mem[coord_cnt] = longint'(c);
    if (coord_cnt < COUNT_TOP) coord_cnt++;
    if (lst) close_set();
  endtask

  // Result checker
  always @(posedge clk) begin
    bar_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (bars_due.size() == 0) begin
        report("unexpected bar, death", out_tdata[DEATH_W-1:0], -1);
      end else begin
        w = bars_due.pop_front();
        if (out_tdata[DEATH_W-1:0] !== w.death) report("death", out_tdata[DEATH_W-1:0], w.death);
        if (out_tuser[0] !== w.inf) report("infinite", out_tuser[0], w.inf);
        if (out_tuser[1] !== w.err) report("error", out_tuser[1], w.err);
        if (out_tlast !== w.last) report("bar_last", out_tlast, w.last);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (idle_mode == IDLE_RECV) out_tready <= ($urandom_range(99) >= 56);
    else if (idle_mode == IDLE_BOTH) out_tready <= ($urandom_range(99) >= 13);
    else out_tready <= 1'b1;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_coord(input logic signed [15:0] c, input bit lst);
    int gap = 0;
    if (idle_mode == IDLE_SEND && $urandom_range(99) < 56) gap = $urandom_range(1, 4);
    if (idle_mode == IDLE_BOTH && $urandom_range(99) < 13) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    take_coord(c, lst);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bars_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers plus a write to an unused index, block idle
  task automatic write_regs(input logic [DIM_W-1:0] d, input logic [DEATH_W-1:0] r);
    cfg_we <= 1'b1; cfg_addr <= REG_DIM; cfg_wdata <= DEATH_W'(d);
    @(posedge clk);
    dim_reg = d;
    cfg_addr <= REG_MAX_RADIUS; cfg_wdata <= r;
    @(posedge clk);
    radius_reg = r;
    cfg_addr <= REG_UNUSED; cfg_wdata <= DEATH_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pattern_coord(input pat_e p, input int idx,
                                                      input int d);
    case (p)
      PAT_ZERO: return '0;
      PAT_EXT:  return ((idx / d) % 2) ? 16'sh7FFF : 16'sh8000;
      PAT_DUP:  return 16'sd5;
      default:  return 16'($urandom);
    endcase
  endfunction

  set_row_t rows [9] = '{
    '{4'd2,  RADIUS_RESET, 2,   PAT_ZERO, EXP_ONE_INF},
    '{4'd2,  RADIUS_RESET, 3,   PAT_RAND, EXP_ERR},
    '{4'd1,  RADIUS_RESET, 2,   PAT_EXT,  EXP_MODEL},
    '{4'd0,  RADIUS_RESET, 2,   PAT_RAND, EXP_MODEL},
    '{4'd15, RADIUS_RESET, 8,   PAT_EXT,  EXP_ONE_INF},
    '{4'd8,  RADIUS_RESET, 16,  PAT_EXT,  EXP_MODEL},
    '{4'd1,  26'd0,        3,   PAT_DUP,  EXP_MODEL},
    '{4'd1,  26'd0,        3,   PAT_RAND, EXP_MODEL},
    '{4'd1,  RADIUS_RESET, 33,  PAT_RAND, EXP_ERR}
  };

  initial begin
    int d, n, nc, items;
    bit bad;
    logic signed [15:0] c;
    bar_t typed_bar;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    coord_cnt = 0;
    dim_reg = DIM_RESET;
    radius_reg = RADIUS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sets
    foreach (rows[r]) begin
      if (r > 0) write_regs(rows[r].dim, rows[r].radius);
      d = (rows[r].dim == 0) ? 1 : (rows[r].dim > NDIM ? NDIM : int'(rows[r].dim));
      for (int i = 0; i < rows[r].ncoord; i++) begin
        c = pattern_coord(rows[r].pat, i, d);
        send_coord(c, i == rows[r].ncoord - 1);
      end
      if (rows[r].exp != EXP_MODEL) begin
        bars_due.delete();
        typed_bar = '{death: '0, inf: (rows[r].exp == EXP_ONE_INF),
                      err: (rows[r].exp == EXP_ERR), last: 1'b1};
        bars_due.insert(0, typed_bar);
      end
      drain();
    end

    // random sets, idling phase follows progress
    items = 0;
    while (items < RAND_ITEMS) begin
      idle_mode = idle_e'((items * 4) / RAND_ITEMS);
      d = $urandom_range(1, 3);
      if ($urandom_range(9) == 0) d = $urandom_range(4, 8);
      n = $urandom_range(1, 6);
      if ($urandom_range(24) == 0) n = $urandom_range(20, 32);
      case ($urandom_range(5))
        0:       write_regs(($urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15))),
                            RADIUS_RESET);
        1:       write_regs(4'(d), DEATH_W'($urandom_range(0, 3000)));
        2:       write_regs(4'(d), DEATH_W'($urandom));
        default: write_regs(4'(d), RADIUS_RESET);
      endcase
      d = (dim_reg == 0) ? 1 : (dim_reg > NDIM ? NDIM : int'(dim_reg));
      // keep each set short so the run stays near its item budget
      if (n * d > SET_CAP) n = SET_CAP / d;
      nc = n * d;
      bad = ($urandom_range(9) == 0) && d > 1;
      if (bad) nc = nc + 1;
      for (int i = 0; i < nc; i++) begin
        c = $urandom_range(1) ? 16'($signed($urandom_range(0, 8)) - 4) : 16'($urandom);
        send_coord(c, i == nc - 1);
      end
      items += nc;
      drain();
    end

    if (fails == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
